// File: hw/rtl/mipsdec_pkg.sv
// ----------------------------------------------------------------------------
// mipsdec_pkg: shared types and codes for the MIPS subset decoder
// Mnemonic and layout codes, opcode and function constants, result record.
// ----------------------------------------------------------------------------
package mipsdec_pkg;

   // Mnemonic codes, in decode priority order
   typedef enum logic [5:0] {
      MN_ADD     = 6'd0,
      MN_SUB     = 6'd1,
      MN_MUL     = 6'd2,
      MN_AND     = 6'd3,
      MN_OR      = 6'd4,
      MN_XOR     = 6'd5,
      MN_SLLV    = 6'd6,
      MN_SRLV    = 6'd7,
      MN_SLT     = 6'd8,
      MN_ADDI    = 6'd9,
      MN_ANDI    = 6'd10,
      MN_ORI     = 6'd11,
      MN_XORI    = 6'd12,
      MN_SLL     = 6'd13,
      MN_SRL     = 6'd14,
      MN_SLTI    = 6'd15,
      MN_LUI     = 6'd16,
      MN_LB      = 6'd17,
      MN_LH      = 6'd18,
      MN_LW      = 6'd19,
      MN_SB      = 6'd20,
      MN_SH      = 6'd21,
      MN_SW      = 6'd22,
      MN_BEQ     = 6'd23,
      MN_BNE     = 6'd24,
      MN_BLEZ    = 6'd25,
      MN_BGTZ    = 6'd26,
      MN_BLTZ    = 6'd27,
      MN_BGEZ    = 6'd28,
      MN_J       = 6'd29,
      MN_JAL     = 6'd30,
      MN_JR      = 6'd31,
      MN_SYSCALL = 6'd32
   } mnemonic_type;

   // Operand layout codes
   typedef enum logic [2:0] {
      LAY_RRR  = 3'd0,
      LAY_RRI  = 3'd1,
      LAY_RI   = 3'd2,
      LAY_ROFF = 3'd3,
      LAY_R    = 3'd4,
      LAY_TGT  = 3'd5,
      LAY_NONE = 3'd6
   } layout_type;

   localparam int MNEMONIC_LAST = 32;

   // Primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_REGIMM  = 6'd1;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLEZ    = 6'd6;
   localparam logic [5:0] OP_BGTZ    = 6'd7;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_XORI    = 6'd14;
   localparam logic [5:0] OP_SPECIAL2 = 6'd28;
   localparam logic [5:0] OP_LB      = 6'd32;
   localparam logic [5:0] OP_LH      = 6'd33;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SB      = 6'd40;
   localparam logic [5:0] OP_SH      = 6'd41;
   localparam logic [5:0] OP_SW      = 6'd43;

   // Exact low 11 bits (shamt + funct) for three-register forms
   localparam logic [10:0] LO_ADD  = 11'd32;
   localparam logic [10:0] LO_SUB  = 11'd34;
   localparam logic [10:0] LO_MUL  = 11'd2;
   localparam logic [10:0] LO_AND  = 11'd36;
   localparam logic [10:0] LO_OR   = 11'd37;
   localparam logic [10:0] LO_XOR  = 11'd38;
   localparam logic [10:0] LO_SLLV = 11'd4;
   localparam logic [10:0] LO_SRLV = 11'd6;
   localparam logic [10:0] LO_SLT  = 11'd42;

   // Function codes for the loose shift matches
   localparam logic [5:0] FN_SLL = 6'd0;
   localparam logic [5:0] FN_SRL = 6'd2;

   // Opcode plus rs for lui (rs must be zero)
   localparam logic [10:0] TOP_LUI = 11'd480;

   // REGIMM rt selectors
   localparam logic [4:0] RT_BLTZ = 5'd0;
   localparam logic [4:0] RT_BGEZ = 5'd1;

   // Exact patterns for jr (bits 20..0) and syscall (whole word)
   localparam logic [20:0] LO_JR      = 21'd8;
   localparam logic [31:0] W_SYSCALL  = 32'd12;

   localparam int RSP_BYTES = 9;

   // Decoded result, recognized in bit 0 upward to jump_target
   typedef struct packed {
      logic [25:0]        jump_target;
      logic signed [15:0] imm_value;
      logic [4:0]         third_reg;
      logic [4:0]         second_reg;
      logic [4:0]         first_reg;
      layout_type         layout;
      mnemonic_type       mnemonic;
      logic               recognized;
   } dec_result_type;

endpackage

// File: hw/rtl/mips_subset_instruction_decoder.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_decoder: MIPS subset instruction classifier
// Decodes one 32-bit word per request into mnemonic, layout and operands.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_*): one 32-bit instruction word per request on
//   req_tdata, taken when req_tvalid and req_tready are both high.
//   Result channel (rsp_*): one decoded record per request, in order.
//   Decoding is a priority match on opcode / function fields; the first
//   matching instruction wins, and words that match nothing come out with
//   recognized = 0 and all other fields zero.
//
// Pipeline and throughput
//   Two register stages: the word is captured in an input register, decoded
//   combinationally, and the record lands in the output register, which
//   drives rsp_*. One request per cycle is sustained while rsp_tready stays
//   high; the single decode pass sets the rate.
//
// Reset and stall
//   Synchronous active-high reset empties both stages. While rsp_tready is
//   low the output holds steady; the input stage can still take one more
//   request, after which req_tready drops until the output drains.
// ----------------------------------------------------------------------------
module mips_subset_instruction_decoder (
   input  logic        clock,
   input  logic        reset,
   // request: [31:0] instr_word
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // result: [0] recognized, [6:1] mnemonic, [9:7] layout, [14:10] first_reg,
   //   [19:15] second_reg, [24:20] third_reg, [40:25] imm_value,
   //   [66:41] jump_target, [71:67] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata
);
   import mipsdec_pkg::*;

   localparam int RES_W = $bits(dec_result_type);

   logic           in_valid_ff, in_valid_in;
   logic [31:0]    in_word_ff, in_word_in;
   logic           out_valid_ff, out_valid_in;
   dec_result_type out_res_ff, out_res_in;
   logic           advance;

   // Field split of the held word
   logic [5:0]  op;
   logic [4:0]  rs, rt, rd, sh;
   logic [5:0]  fn;
   logic [10:0] lo11;
   logic [10:0] top11;
   logic [20:0] lo21;
   logic [15:0] imm;
   logic [25:0] tg;

   // Decode scratch
   logic         hit;
   mnemonic_type mn;
   layout_type   lay;
   logic [4:0]   r1, r2, r3;
   logic [15:0]  iv;
   logic [25:0]  tv;

   // Input stage moves on when the output is empty or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_word_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign op    = in_word_ff[31:26];
   assign rs    = in_word_ff[25:21];
   assign rt    = in_word_ff[20:16];
   assign rd    = in_word_ff[15:11];
   assign sh    = in_word_ff[10:6];
   assign fn    = in_word_ff[5:0];
   assign lo11  = in_word_ff[10:0];
   assign top11 = in_word_ff[31:21];
   assign lo21  = in_word_ff[20:0];
   assign imm   = in_word_ff[15:0];
   assign tg    = in_word_ff[25:0];

   // Priority decode; unused fields stay zero
   always_comb begin
      hit = 1'b1;
      mn  = MN_ADD;
      lay = LAY_RRR;
      r1  = '0;
      r2  = '0;
      r3  = '0;
      iv  = '0;
      tv  = '0;
      priority if (op == OP_SPECIAL && lo11 == LO_ADD) begin
         mn = MN_ADD;  r1 = rd; r2 = rs; r3 = rt;
      end else if (op == OP_SPECIAL && lo11 == LO_SUB) begin
         mn = MN_SUB;  r1 = rd; r2 = rs; r3 = rt;
      end else if (op == OP_SPECIAL2 && lo11 == LO_MUL) begin
         mn = MN_MUL;  r1 = rd; r2 = rs; r3 = rt;
      end else if (op == OP_SPECIAL && lo11 == LO_AND) begin
         mn = MN_AND;  r1 = rd; r2 = rs; r3 = rt;
      end else if (op == OP_SPECIAL && lo11 == LO_OR) begin
         mn = MN_OR;   r1 = rd; r2 = rs; r3 = rt;
      end else if (op == OP_SPECIAL && lo11 == LO_XOR) begin
         mn = MN_XOR;  r1 = rd; r2 = rs; r3 = rt;
      end else if (op == OP_SPECIAL && lo11 == LO_SLLV) begin
         // variable shifts print t before s
         mn = MN_SLLV; r1 = rd; r2 = rt; r3 = rs;
      end else if (op == OP_SPECIAL && lo11 == LO_SRLV) begin
         mn = MN_SRLV; r1 = rd; r2 = rt; r3 = rs;
      end else if (op == OP_SPECIAL && lo11 == LO_SLT) begin
         mn = MN_SLT;  r1 = rd; r2 = rs; r3 = rt;
      end else if (op == OP_ADDI) begin
         mn = MN_ADDI; lay = LAY_RRI; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_ANDI) begin
         mn = MN_ANDI; lay = LAY_RRI; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_ORI) begin
         mn = MN_ORI;  lay = LAY_RRI; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_XORI) begin
         mn = MN_XORI; lay = LAY_RRI; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_SPECIAL && fn == FN_SLL) begin
         // rs is not checked; all-zero word lands here
         mn = MN_SLL;  lay = LAY_RRI; r1 = rd; r2 = rt; iv = {11'd0, sh};
      end else if (op == OP_SPECIAL && fn == FN_SRL) begin
         mn = MN_SRL;  lay = LAY_RRI; r1 = rd; r2 = rt; iv = {11'd0, sh};
      end else if (op == OP_SLTI) begin
         mn = MN_SLTI; lay = LAY_RRI; r1 = rt; r2 = rs; iv = imm;
      end else if (top11 == TOP_LUI) begin
         mn = MN_LUI;  lay = LAY_RI;  r1 = rt; iv = imm;
      end else if (op == OP_LB) begin
         mn = MN_LB;   lay = LAY_ROFF; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_LH) begin
         mn = MN_LH;   lay = LAY_ROFF; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_LW) begin
         mn = MN_LW;   lay = LAY_ROFF; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_SB) begin
         mn = MN_SB;   lay = LAY_ROFF; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_SH) begin
         mn = MN_SH;   lay = LAY_ROFF; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_SW) begin
         mn = MN_SW;   lay = LAY_ROFF; r1 = rt; r2 = rs; iv = imm;
      end else if (op == OP_BEQ) begin
         mn = MN_BEQ;  lay = LAY_RRI; r1 = rs; r2 = rt; iv = imm;
      end else if (op == OP_BNE) begin
         mn = MN_BNE;  lay = LAY_RRI; r1 = rs; r2 = rt; iv = imm;
      end else if (op == OP_BLEZ && rt == '0) begin
         mn = MN_BLEZ; lay = LAY_RI;  r1 = rs; iv = imm;
      end else if (op == OP_BGTZ && rt == '0) begin
         mn = MN_BGTZ; lay = LAY_RI;  r1 = rs; iv = imm;
      end else if (op == OP_REGIMM && rt == RT_BLTZ) begin
         mn = MN_BLTZ; lay = LAY_RI;  r1 = rs; iv = imm;
      end else if (op == OP_REGIMM && rt == RT_BGEZ) begin
         mn = MN_BGEZ; lay = LAY_RI;  r1 = rs; iv = imm;
      end else if (op == OP_J) begin
         mn = MN_J;    lay = LAY_TGT; tv = tg;
      end else if (op == OP_JAL) begin
         mn = MN_JAL;  lay = LAY_TGT; tv = tg;
      end else if (op == OP_SPECIAL && lo21 == LO_JR) begin
         mn = MN_JR;   lay = LAY_R;   r1 = rs;
      end else if (in_word_ff == W_SYSCALL) begin
         mn = MN_SYSCALL; lay = LAY_NONE;
      end else begin
         hit = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in           = in_valid_ff;
         out_res_in.recognized  = hit;
         out_res_in.mnemonic    = mn;
         out_res_in.layout      = lay;
         out_res_in.first_reg   = r1;
         out_res_in.second_reg  = r2;
         out_res_in.third_reg   = r3;
         out_res_in.imm_value   = iv;
         out_res_in.jump_target = tv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_word_ff <= in_word_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_BYTES * 8 - RES_W){1'b0}}, out_res_ff};

endmodule

// File: hw/rtl/mipsdec_checker.sv
// ----------------------------------------------------------------------------
// mipsdec_checker: port-level checks for the MIPS subset decoder
// Watches the result channel for reset, hold and record consistency.
// ----------------------------------------------------------------------------
module mipsdec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   import mipsdec_pkg::*;

   logic unused_req;
   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata);

   // Both stages are empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Unmatched word carries nothing but zeros
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[71:1] == '0)
      else $error("unrecognized result has nonzero fields");

   // Recognized record uses legal codes and zero padding
   a_codes_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[6:1] <= 6'(MNEMONIC_LAST) && rsp_tdata[9:7] <= LAY_NONE
         && rsp_tdata[71:67] == '0)
      else $error("illegal mnemonic or layout code");

   // Jump target only appears for target layout
   a_target_layout: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66:41] != '0 |-> rsp_tdata[9:7] == LAY_TGT)
      else $error("jump target set outside target layout");

endmodule

bind mips_subset_instruction_decoder mipsdec_checker u_mipsdec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for mips_subset_instruction_decoder
// Streams instruction words into the decoder with bursty requests and a
// stalling result side. Each word is decoded by a bench-side model and the
// returned record is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   import mipsdec_pkg::*;

   localparam int RANDOM_WORDS = 810;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [31:0] word;
      bit          drain_first;   // hold off until every decode is back
   } fetch_slot_type;

   typedef struct {
      logic [31:0]    word;
      dec_result_type rec;
   } pending_decode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // [31:0] instr_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [0] recognized, [6:1] mnemonic, [9:7] layout,
                                   // [14:10] first_reg, [19:15] second_reg,
                                   // [24:20] third_reg, [40:25] imm_value,
                                   // [66:41] jump_target, [71:67] zero

   fetch_slot_type     fetch_q[$];    // words still to be sent
   pending_decode_type decode_q[$];   // decodes owed by the block, oldest first

   int mismatch_count = 0;
   int results_seen   = 0;
   int unrecognized   = 0;
   int drain_pauses   = 0;
   int stall_cycles   = 0;
   int cycle_count;
   int burst_left     = 1;
   int gap_left       = 0;
   int stall_phase    = 0;
   int mnemonic_hits[MNEMONIC_LAST+1];

   mips_subset_instruction_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Bench-side decoder: priority chain, first match wins, unused fields zero
   // -------------------------------------------------------------------------
   function automatic dec_result_type make_record(mnemonic_type mn, layout_type lay,
                                                  logic [4:0] r1, logic [4:0] r2,
                                                  logic [4:0] r3, logic [15:0] imm,
                                                  logic [25:0] tgt);
      dec_result_type r;
      r.recognized  = 1'b1;
      r.mnemonic    = mn;
      r.layout      = lay;
      r.first_reg   = r1;
      r.second_reg  = r2;
      r.third_reg   = r3;
      r.imm_value   = imm;
      r.jump_target = tgt;
      return r;
   endfunction

   function automatic dec_result_type decode_word(logic [31:0] w);
      logic [5:0]  op;
      logic [10:0] top11;
      logic [4:0]  rs, rt, rd, sh;
      logic [5:0]  fn;
      logic [10:0] lo11;
      logic [20:0] lo21;
      logic [15:0] imm;
      logic [15:0] shamt;
      logic [25:0] tgt;
      dec_result_type r;
      op    = w[31:26];
      top11 = w[31:21];
      rs    = w[25:21];
      rt    = w[20:16];
      rd    = w[15:11];
      sh    = w[10:6];
      fn    = w[5:0];
      lo11  = w[10:0];
      lo21  = w[20:0];
      imm   = w[15:0];
      shamt = {11'd0, sh};
      tgt   = w[25:0];
      r     = '0;
      if      (op == OP_SPECIAL && lo11 == LO_ADD)  r = make_record(MN_ADD,  LAY_RRR, rd, rs, rt, 0, 0);
      else if (op == OP_SPECIAL && lo11 == LO_SUB)  r = make_record(MN_SUB,  LAY_RRR, rd, rs, rt, 0, 0);
      else if (op == OP_SPECIAL2 && lo11 == LO_MUL) r = make_record(MN_MUL,  LAY_RRR, rd, rs, rt, 0, 0);
      else if (op == OP_SPECIAL && lo11 == LO_AND)  r = make_record(MN_AND,  LAY_RRR, rd, rs, rt, 0, 0);
      else if (op == OP_SPECIAL && lo11 == LO_OR)   r = make_record(MN_OR,   LAY_RRR, rd, rs, rt, 0, 0);
      else if (op == OP_SPECIAL && lo11 == LO_XOR)  r = make_record(MN_XOR,  LAY_RRR, rd, rs, rt, 0, 0);
      // variable shifts print t before s
      else if (op == OP_SPECIAL && lo11 == LO_SLLV) r = make_record(MN_SLLV, LAY_RRR, rd, rt, rs, 0, 0);
      else if (op == OP_SPECIAL && lo11 == LO_SRLV) r = make_record(MN_SRLV, LAY_RRR, rd, rt, rs, 0, 0);
      else if (op == OP_SPECIAL && lo11 == LO_SLT)  r = make_record(MN_SLT,  LAY_RRR, rd, rs, rt, 0, 0);
      else if (op == OP_ADDI) r = make_record(MN_ADDI, LAY_RRI, rt, rs, 0, imm, 0);
      else if (op == OP_ANDI) r = make_record(MN_ANDI, LAY_RRI, rt, rs, 0, imm, 0);
      else if (op == OP_ORI)  r = make_record(MN_ORI,  LAY_RRI, rt, rs, 0, imm, 0);
      else if (op == OP_XORI) r = make_record(MN_XORI, LAY_RRI, rt, rs, 0, imm, 0);
      // loose shifts: rs not looked at, so the all-zero word lands here
      else if (op == OP_SPECIAL && fn == FN_SLL) r = make_record(MN_SLL, LAY_RRI, rd, rt, 0, shamt, 0);
      else if (op == OP_SPECIAL && fn == FN_SRL) r = make_record(MN_SRL, LAY_RRI, rd, rt, 0, shamt, 0);
      else if (op == OP_SLTI)     r = make_record(MN_SLTI, LAY_RRI, rt, rs, 0, imm, 0);
      else if (top11 == TOP_LUI)  r = make_record(MN_LUI,  LAY_RI,  rt, 0, 0, imm, 0);
      else if (op == OP_LB) r = make_record(MN_LB, LAY_ROFF, rt, rs, 0, imm, 0);
      else if (op == OP_LH) r = make_record(MN_LH, LAY_ROFF, rt, rs, 0, imm, 0);
      else if (op == OP_LW) r = make_record(MN_LW, LAY_ROFF, rt, rs, 0, imm, 0);
      else if (op == OP_SB) r = make_record(MN_SB, LAY_ROFF, rt, rs, 0, imm, 0);
      else if (op == OP_SH) r = make_record(MN_SH, LAY_ROFF, rt, rs, 0, imm, 0);
      else if (op == OP_SW) r = make_record(MN_SW, LAY_ROFF, rt, rs, 0, imm, 0);
      else if (op == OP_BEQ) r = make_record(MN_BEQ, LAY_RRI, rs, rt, 0, imm, 0);
      else if (op == OP_BNE) r = make_record(MN_BNE, LAY_RRI, rs, rt, 0, imm, 0);
      else if (op == OP_BLEZ && rt == 5'd0) r = make_record(MN_BLEZ, LAY_RI, rs, 0, 0, imm, 0);
      else if (op == OP_BGTZ && rt == 5'd0) r = make_record(MN_BGTZ, LAY_RI, rs, 0, 0, imm, 0);
      else if (op == OP_REGIMM && rt == RT_BLTZ) r = make_record(MN_BLTZ, LAY_RI, rs, 0, 0, imm, 0);
      else if (op == OP_REGIMM && rt == RT_BGEZ) r = make_record(MN_BGEZ, LAY_RI, rs, 0, 0, imm, 0);
      else if (op == OP_J)   r = make_record(MN_J,   LAY_TGT, 0, 0, 0, 0, tgt);
      else if (op == OP_JAL) r = make_record(MN_JAL, LAY_TGT, 0, 0, 0, 0, tgt);
      else if (op == OP_SPECIAL && lo21 == LO_JR) r = make_record(MN_JR, LAY_R, rs, 0, 0, 0, 0);
      else if (w == W_SYSCALL) r = make_record(MN_SYSCALL, LAY_NONE, 0, 0, 0, 0, 0);
      return r;
   endfunction

   // Builds a well-formed word for one instruction; free fields come from fill
   function automatic logic [31:0] encode_word(mnemonic_type mn, logic [31:0] fill);
      logic [31:0] w;
      case (mn)
         MN_ADD:     w = {OP_SPECIAL, fill[25:11], LO_ADD};
         MN_SUB:     w = {OP_SPECIAL, fill[25:11], LO_SUB};
         MN_MUL:     w = {OP_SPECIAL2, fill[25:11], LO_MUL};
         MN_AND:     w = {OP_SPECIAL, fill[25:11], LO_AND};
         MN_OR:      w = {OP_SPECIAL, fill[25:11], LO_OR};
         MN_XOR:     w = {OP_SPECIAL, fill[25:11], LO_XOR};
         MN_SLLV:    w = {OP_SPECIAL, fill[25:11], LO_SLLV};
         MN_SRLV:    w = {OP_SPECIAL, fill[25:11], LO_SRLV};
         MN_SLT:     w = {OP_SPECIAL, fill[25:11], LO_SLT};
         MN_ADDI:    w = {OP_ADDI, fill[25:0]};
         MN_ANDI:    w = {OP_ANDI, fill[25:0]};
         MN_ORI:     w = {OP_ORI, fill[25:0]};
         MN_XORI:    w = {OP_XORI, fill[25:0]};
         MN_SLL:     w = {OP_SPECIAL, fill[25:6], FN_SLL};
         MN_SRL:     w = {OP_SPECIAL, fill[25:6], FN_SRL};
         MN_SLTI:    w = {OP_SLTI, fill[25:0]};
         MN_LUI:     w = {TOP_LUI, fill[20:0]};
         MN_LB:      w = {OP_LB, fill[25:0]};
         MN_LH:      w = {OP_LH, fill[25:0]};
         MN_LW:      w = {OP_LW, fill[25:0]};
         MN_SB:      w = {OP_SB, fill[25:0]};
         MN_SH:      w = {OP_SH, fill[25:0]};
         MN_SW:      w = {OP_SW, fill[25:0]};
         MN_BEQ:     w = {OP_BEQ, fill[25:0]};
         MN_BNE:     w = {OP_BNE, fill[25:0]};
         MN_BLEZ:    w = {OP_BLEZ, fill[25:21], 5'd0, fill[15:0]};
         MN_BGTZ:    w = {OP_BGTZ, fill[25:21], 5'd0, fill[15:0]};
         MN_BLTZ:    w = {OP_REGIMM, fill[25:21], RT_BLTZ, fill[15:0]};
         MN_BGEZ:    w = {OP_REGIMM, fill[25:21], RT_BGEZ, fill[15:0]};
         MN_J:       w = {OP_J, fill[25:0]};
         MN_JAL:     w = {OP_JAL, fill[25:0]};
         MN_JR:      w = {OP_SPECIAL, fill[25:21], LO_JR};
         MN_SYSCALL: w = W_SYSCALL;
         default:    w = fill;
      endcase
      return w;
   endfunction

   task automatic queue_word(logic [31:0] w, bit drain_first);
      fetch_slot_type s;
      s.word        = w;
      s.drain_first = drain_first;
      fetch_q.push_back(s);
   endtask

   task automatic check_field(string field, logic [31:0] word, logic [31:0] want_v,
                              logic [31:0] got_v);
      if (want_v !== got_v) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: result %0d word %08h %s expected %0h got %0h",
                     results_seen, word, field, want_v, got_v);
      end
   endtask

   // -------------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps. A word
   // flagged drain_first is held back until every owed decode has come out.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      pending_decode_type p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            p.word = req_tdata;
            p.rec  = decode_word(req_tdata);
            decode_q.push_back(p);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (fetch_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (fetch_q[0].drain_first && decode_q.size() != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               if (fetch_q[0].drain_first)
                  drain_pauses++;
               req_tdata  <= fetch_q[0].word;
               req_tvalid <= 1'b1;
               void'(fetch_q.pop_front());
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(40, 1);
                  // a third of the bursts run straight into the next one
                  gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result side back-pressure: four modes that take turns in rotation
   // (always ready, coin flip, ready a quarter of the time, mostly ready).
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      stall_phase++;
      case (stall_phase[8:7])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(1, 0));
         2'd2:    rsp_tready <= (stall_phase[2:0] < 3'd2);
         default: rsp_tready <= ($urandom_range(4, 0) != 0);
      endcase
      if (!reset && rsp_tvalid && !rsp_tready)
         stall_cycles++;
   end

   // -------------------------------------------------------------------------
   // Result monitor: every accepted record against the oldest owed decode
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      pending_decode_type p;
      dec_result_type     got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[66:0];
         if (decode_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("mismatch: unexpected result %0h with no request owed",
                        rsp_tdata);
         end else begin
            p = decode_q.pop_front();
            check_field("recognized", p.word, 32'(p.rec.recognized),
                        32'(got.recognized));
            check_field("mnemonic", p.word, 32'(p.rec.mnemonic), 32'(got.mnemonic));
            check_field("layout", p.word, 32'(p.rec.layout), 32'(got.layout));
            check_field("first_reg", p.word, 32'(p.rec.first_reg), 32'(got.first_reg));
            check_field("second_reg", p.word, 32'(p.rec.second_reg),
                        32'(got.second_reg));
            check_field("third_reg", p.word, 32'(p.rec.third_reg), 32'(got.third_reg));
            check_field("imm_value", p.word, {16'd0, p.rec.imm_value},
                        {16'd0, got.imm_value});
            check_field("jump_target", p.word, 32'(p.rec.jump_target),
                        32'(got.jump_target));
            check_field("pad", p.word, 32'd0, 32'(rsp_tdata[71:67]));
            if (p.rec.recognized)
               mnemonic_hits[p.rec.mnemonic]++;
            else
               unrecognized++;
         end
         results_seen++;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0] fill;
      logic [31:0] w;
      int          kind;
      int          kinds_hit;

      // every instruction once, free fields alternately all zeros / all ones
      for (int m = 0; m <= MNEMONIC_LAST; m++)
         queue_word(encode_word(mnemonic_type'(m), m[0] ? 32'hFFFF_FFFF : 32'h0), 1'b0);
      queue_word(encode_word(MN_ADDI, 32'h0000_7FFF), 1'b0);   // largest immediate
      queue_word(encode_word(MN_LW, 32'h03FF_8000), 1'b0);     // most negative offset
      queue_word(32'h0000_0000, 1'b0);                         // all-zero word is sll
      queue_word(encode_word(MN_SLL, 32'h03E0_0000), 1'b0);    // sll ignores rs
      queue_word(encode_word(MN_ADD, 32'h0) | 32'h0000_0040, 1'b0); // shamt set: no match
      queue_word(encode_word(MN_JR, 32'h0) | 32'h0001_0000, 1'b0);  // jr with rt set
      queue_word(W_SYSCALL | 32'h0000_0800, 1'b0);             // syscall with extra bit
      queue_word({TOP_LUI | 11'd1, 21'h1F_ABCD}, 1'b0);       // lui with rs nonzero
      queue_word({OP_BLEZ, 5'd3, 5'd1, 16'h1234}, 1'b0);       // blez with rt nonzero
      queue_word({OP_REGIMM, 5'd7, 5'd2, 16'h8001}, 1'b0);     // regimm, unknown rt
      queue_word(32'hFFFF_FFFF, 1'b0);

      // mostly well-formed words with random fields; the rest single-bit
      // corruptions of a valid word and raw noise
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         kind = $urandom_range(99, 0);
         fill = $urandom();
         if ($urandom_range(15, 0) == 0)
            fill = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0;
         w = encode_word(mnemonic_type'($urandom_range(MNEMONIC_LAST, 0)), fill);
         if (kind >= 85)
            w = $urandom();
         else if (kind >= 65)
            w = w ^ (32'd1 << $urandom_range(31, 0));
         queue_word(w, (n % 200) == 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (fetch_q.size() != 0 || req_tvalid || decode_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      kinds_hit = 0;
      for (int m = 0; m <= MNEMONIC_LAST; m++)
         if (mnemonic_hits[m] != 0)
            kinds_hit++;
      $display("decoded %0d words: %0d of %0d instruction kinds seen, %0d unmatched",
               results_seen, kinds_hit, MNEMONIC_LAST + 1, unrecognized);
      $display("full drains %0d, result stall cycles %0d, mismatches %0d",
               drain_pauses, stall_cycles, mismatch_count);
      if (mismatch_count == 0)
         $display("** mips_subset_instruction_decoder: PASSED **");
      else
         $display("** mips_subset_instruction_decoder: FAILED **");
      $finish;
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("timeout after %0d cycles, %0d decodes owed", cycle_count, decode_q.size());
      $display("** mips_subset_instruction_decoder: FAILED **");
      $finish;
   end

endmodule

// File: mips_subset_instruction_decoder.f
hw/rtl/mipsdec_pkg.sv
hw/rtl/mips_subset_instruction_decoder.sv
hw/rtl/mipsdec_checker.sv
tb/tb.sv
